// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL modules; used by rsm_datapath.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define RSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RSM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/rsm_pkg.sv -----
// Shared types, constants and coefficient ROM for the stereo resampler.
// No dependencies.
package rsm_pkg;

	localparam int SampleW = 16;
	localparam int StepW   = 20;
	localparam int FracW   = 16;
	localparam int WaitW   = 5;
	localparam int CntW    = 6;
	localparam int AccW    = 19;

	localparam logic [StepW-1:0] STEP_MIN   = 20'd1024;
	localparam logic [StepW-1:0] STEP_RESET = 20'd65536;
	localparam logic [WaitW-1:0] WAIT_RESET = 5'd4;
	localparam logic [1:0]       TAP_LAST   = 2'd3;
	localparam logic [CntW-1:0]  CNT_LAST   = 6'd63;

	typedef logic [1:0] tap_t;
	typedef logic signed [SampleW-1:0] sample_t;

	typedef struct packed {
		logic accept;   // input transfer: shift histories, count down wait
		logic mac_en;   // accumulate one tap
		logic emit;     // final tap: load output register, advance phase
		tap_t tap;
	} cmd_t;

	typedef struct packed {
		logic wait_ready; // next input completes the wait
		logic out_free;   // output register can take a result this cycle
		logic last_out;   // result being emitted ends the burst
	} status_t;

	// First half of the 64-phase ROM; row 63-k is row k reversed.
	localparam logic [15:0] COEF_HALF [32][4] = '{
		'{16'h0c39, 16'h66ad, 16'h0d46, 16'hffdf}, '{16'h0b39, 16'h6696, 16'h0e5f, 16'hffd8},
		'{16'h0a44, 16'h6669, 16'h0f83, 16'hffd0}, '{16'h095a, 16'h6626, 16'h10b4, 16'hffc8},
		'{16'h087d, 16'h65cd, 16'h11f0, 16'hffbf}, '{16'h07ab, 16'h655e, 16'h1338, 16'hffb6},
		'{16'h06e4, 16'h64d9, 16'h148c, 16'hffac}, '{16'h0628, 16'h643f, 16'h15eb, 16'hffa1},
		'{16'h0577, 16'h638f, 16'h1756, 16'hff96}, '{16'h04d1, 16'h62cb, 16'h18cb, 16'hff8a},
		'{16'h0435, 16'h61f3, 16'h1a4c, 16'hff7e}, '{16'h03a4, 16'h6106, 16'h1bd7, 16'hff71},
		'{16'h031c, 16'h6007, 16'h1d6c, 16'hff64}, '{16'h029f, 16'h5ef5, 16'h1f0b, 16'hff56},
		'{16'h022a, 16'h5dd0, 16'h20b3, 16'hff48}, '{16'h01be, 16'h5c9a, 16'h2264, 16'hff3a},
		'{16'h015b, 16'h5b53, 16'h241e, 16'hff2c}, '{16'h0101, 16'h59fc, 16'h25e0, 16'hff1e},
		'{16'h00ae, 16'h5896, 16'h27a9, 16'hff10}, '{16'h0063, 16'h5720, 16'h297a, 16'hff02},
		'{16'h001f, 16'h559d, 16'h2b50, 16'hfef4}, '{16'hffe2, 16'h540d, 16'h2d2c, 16'hfee8},
		'{16'hffac, 16'h5270, 16'h2f0d, 16'hfedb}, '{16'hff7c, 16'h50c7, 16'h30f3, 16'hfed0},
		'{16'hff53, 16'h4f14, 16'h32dc, 16'hfec6}, '{16'hff2e, 16'h4d57, 16'h34c8, 16'hfebd},
		'{16'hff0f, 16'h4b91, 16'h36b6, 16'hfeb6}, '{16'hfef5, 16'h49c2, 16'h38a5, 16'hfeb0},
		'{16'hfedf, 16'h47ed, 16'h3a95, 16'hfeac}, '{16'hfece, 16'h4611, 16'h3c85, 16'hfeab},
		'{16'hfec0, 16'h4430, 16'h3e74, 16'hfeac}, '{16'hfeb6, 16'h424a, 16'h4060, 16'hfeaf}
	};

	function automatic logic signed [15:0] coef(input logic [5:0] row, input tap_t tap);
		logic [15:0] c;
		if (!row[5]) begin
			c = COEF_HALF[row[4:0]][tap];
		end else begin
			c = COEF_HALF[~row[4:0]][~tap];
		end
		return $signed(c);
	endfunction

endpackage

// ----- rtl/rsm_in_if.sv -----
// Input channel: one stereo sample per transfer.
// Depends on rsm_pkg.
interface rsm_in_if import rsm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;

	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

// ----- rtl/rsm_out_if.sv -----
// Output channel: one resampled stereo sample per transfer.
// Depends on rsm_pkg.
interface rsm_out_if import rsm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;
	logic    last;

	modport source (output valid, left_out, right_out, last, input ready);
	modport sink (input valid, left_out, right_out, last, output ready);
endinterface

// ----- rtl/rsm_ctrl.sv -----
// Controller FSM: input handshake and tap sequencing.
// Depends on rsm_pkg.
module rsm_ctrl import rsm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_MAC  = 2'b10
	} state_t;

	state_t state_q, state_d;
	tap_t   tap_q, tap_d;

	always_comb begin
		state_d  = state_q;
		tap_d    = tap_q;
		cmd      = '0;
		cmd.tap  = tap_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				tap_d    = '0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.wait_ready) begin
						state_d = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				if (tap_q != TAP_LAST) begin
					cmd.mac_en = 1'b1;
					tap_d      = tap_q + 2'd1;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					tap_d    = '0;
					if (status.last_out) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				tap_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

endmodule

// ----- rtl/rsm_datapath.sv -----
// Datapath: histories, phase, wait count, tap-serial MAC per channel, output register.
// Depends on rsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsm_datapath import rsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  logic             cfg_we,
	input  logic [StepW-1:0] cfg_wdata,
	input  sample_t          left_in,
	input  sample_t          right_in,
	output logic             out_valid,
	input  logic             out_ready,
	output sample_t          left_out,
	output sample_t          right_out,
	output logic             last
);

	logic [StepW-1:0] step_q;
	sample_t          hist_l_q [5];
	sample_t          hist_r_q [5];
	logic [FracW-1:0] frac_q;
	logic [WaitW-1:0] wait_q;
	logic [CntW-1:0]  cnt_q;
	logic signed [AccW-1:0] acc_l_q, acc_r_q;
	logic             out_valid_q;
	sample_t          left_out_q, right_out_q;
	logic             last_q;

	logic [StepW-1:0]       step_eff;
	logic [StepW:0]         ph_sum;
	logic [WaitW-1:0]       adv;
	logic signed [15:0]     c;
	sample_t                h_l, h_r;
	logic signed [31:0]     prod_l, prod_r;
	logic signed [AccW-1:0] sum_l, sum_r;

	function automatic sample_t sat16(input logic signed [AccW-1:0] v);
		if (v > $signed(19'sd32767)) begin
			return 16'sh7fff;
		end else if (v < -$signed(19'sd32768)) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// phase and carry
	assign step_eff = (step_q < STEP_MIN) ? STEP_MIN : step_q;
	assign ph_sum   = {{(StepW+1-FracW){1'b0}}, frac_q} + {1'b0, step_eff};
	assign adv      = ph_sum[StepW:FracW];

	// tap select: four oldest samples
	always_comb begin
		case (cmd.tap)
			2'd0:    begin h_l = hist_l_q[0]; h_r = hist_r_q[0]; end
			2'd1:    begin h_l = hist_l_q[1]; h_r = hist_r_q[1]; end
			2'd2:    begin h_l = hist_l_q[2]; h_r = hist_r_q[2]; end
			default: begin h_l = hist_l_q[3]; h_r = hist_r_q[3]; end
		endcase
	end

	assign c      = coef(frac_q[FracW-1 -: 6], cmd.tap);
	assign prod_l = h_l * c;
	assign prod_r = h_r * c;
	// >>>15 is a drop of the low bits; 17-bit result sign-extended into the accumulator
	assign sum_l  = ((cmd.tap == '0) ? '0 : acc_l_q)
		+ {{(AccW-17){prod_l[31]}}, prod_l[31:15]};
	assign sum_r  = ((cmd.tap == '0) ? '0 : acc_r_q)
		+ {{(AccW-17){prod_r[31]}}, prod_r[31:15]};

	assign status.wait_ready = (wait_q <= 5'd1);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.last_out   = (adv != '0) || (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_RESET;
			frac_q      <= '0;
			wait_q      <= WAIT_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				hist_l_q[i] <= '0;
				hist_r_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				for (int i = 0; i < 4; i++) begin
					hist_l_q[i] <= hist_l_q[i+1];
					hist_r_q[i] <= hist_r_q[i+1];
				end
				hist_l_q[4] <= left_in;
				hist_r_q[4] <= right_in;
				if (wait_q != '0) begin
					wait_q <= wait_q - 5'd1;
				end
				cnt_q <= '0;
			end
			if (cmd.emit) begin
				frac_q <= ph_sum[FracW-1:0];
				cnt_q  <= cnt_q + 6'd1;
				if (status.last_out) begin
					wait_q <= adv;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			acc_l_q <= sum_l;
			acc_r_q <= sum_r;
		end
		if (cmd.emit) begin
			left_out_q  <= sat16(sum_l);
			right_out_q <= sat16(sum_r);
			last_q      <= status.last_out;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign last      = last_q;

	`RSM_ASSERT(a_emit_room, cmd.emit |-> (!out_valid_q || out_ready), "emit overwrote a pending result")
	`RSM_NEVER(a_accept_emit, cmd.accept && cmd.emit, "input transfer during an output burst")
	`RSM_ASSERT(a_valid_src, $rose(out_valid_q) |-> $past(cmd.emit), "result valid without emit")
	`RSM_ASSERT(a_wait_set, (cmd.emit && (adv != '0)) |=> (wait_q != '0), "carry did not set the wait")

endmodule

// ----- rtl/stereo_lut_cubic_resampler_unit.sv -----
// Top level of the stereo four-tap polyphase resampler.
// Depends on rsm_pkg, rsm_in_if, rsm_out_if, rsm_ctrl, rsm_datapath.
//
//  channel   | role | transfer carries
//  ----------+------+------------------------------------------
//  samples   | sink | left_in, right_in (16-bit signed)
//  results   | src  | left_out, right_out (16-bit signed), last
//  cfg_we    | in   | phase_step write, cfg_wdata[19:0]
//
// An input transfer that completes the wait starts a burst; each result
// then runs its four taps through the shared per-channel multiplier (one
// tap per cycle while the output register has room for the final tap).
// A full output register with results.ready low stalls the final tap.
// Samples are taken only between bursts. arst_n clears histories and phase,
// sets the wait count to 4 and sets phase_step to 65536.
module stereo_lut_cubic_resampler_unit import rsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [StepW-1:0] cfg_wdata,
	rsm_in_if.sink           samples,
	rsm_out_if.source        results
);

	cmd_t    cmd;
	status_t status;

	// sequencer: idle/accept, then tap-serial MAC with emit on the last tap
	rsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// state, filter arithmetic and output register
	rsm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.left_in   (samples.left_in),
		.right_in  (samples.right_in),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.left_out  (results.left_out),
		.right_out (results.right_out),
		.last      (results.last)
	);

endmodule
